>>> design/lru_key_value_cache_defines.svh
// Assertion macros shared by the LRU key-value cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH
`ifndef SYNTHESIS
`define LKVC_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lkvc assertion failed");
`define LKVC_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("lkvc assertion failed");
`else
`define LKVC_ASSERT(name, clk, rst, prop)
`define LKVC_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

>>> design/lkvc_pkg.sv
// Shared constants, types and codes of the LRU key-value cache.
`timescale 1ns / 1ps
`default_nettype none
package lkvc_pkg;

  localparam int CAPACITY  = 16;
  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  localparam int CFG_W     = 5;
  localparam int CFG_RESET = 16;
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int LIM_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int ACT_W     = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUT      = 2'd0,
    ACT_GET      = 2'd1,
    ACT_CONTAINS = 2'd2
  } action_t;

  typedef struct packed {
    logic             valid;
    action_t          action;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             status;
  } rsp_t;

endpackage
`default_nettype wire

>>> design/lkvc_store.sv
// Entry store of the cache: parallel key match, recency ranks and update.
`timescale 1ns / 1ps
`default_nettype none
`include "lru_key_value_cache_defines.svh"
module lkvc_store (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [lkvc_pkg::CFG_W-1:0] max_entries,
  input  wire lkvc_pkg::req_t            req,
  output lkvc_pkg::rsp_t                 rsp
);
  import lkvc_pkg::*;

  logic [CAPACITY-1:0] entry_valid;
  logic [KEY_W-1:0]    entry_key     [CAPACITY];
  logic [VAL_W-1:0]    entry_data    [CAPACITY];
  logic [IDX_W-1:0]    entry_recency [CAPACITY];
  logic [CNT_W-1:0]    entry_count;

  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] free_oh;
  logic [CAPACITY-1:0] victim_oh;
  logic [CAPACITY-1:0] target_oh;
  logic [IDX_W-1:0]    rank_next [CAPACITY];
  logic [CAPACITY-1:0] rank_we;
  logic [IDX_W-1:0]    hit_rank;
  logic [IDX_W-1:0]    oldest_rank;
  logic [VAL_W-1:0]    hit_data;
  logic [LIM_W-1:0]    limit;
  logic                hit;
  logic                is_put;
  logic                is_get;
  logic                touch;
  logic                insert;
  logic                grow;

  always_comb begin
    hit_rank = '0;
    hit_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = entry_valid[i] && (entry_key[i] == req.key);
      if (match[i]) begin
        hit_rank = hit_rank | entry_recency[i];
        hit_data = hit_data | entry_data[i];
      end
    end
    hit = |match;
  end

  // Ranks of valid entries are always a permutation of 0..count-1, so the
  // least recent entry is the one whose rank equals count-1.
  assign oldest_rank = IDX_W'(entry_count - CNT_W'(1));
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      victim_oh[i] = entry_valid[i] && (entry_recency[i] == oldest_rank);
    end
  end

  // Lowest free slot.
  assign free_oh = ~entry_valid & (entry_valid + CAPACITY'(1));

  always_comb begin
    limit = LIM_W'(max_entries);
    if (limit == '0) begin
      limit = LIM_W'(1);
    end else if (limit > LIM_W'(CAPACITY)) begin
      limit = LIM_W'(CAPACITY);
    end
  end
  assign grow = LIM_W'(entry_count) < limit;

  always_comb begin
    is_put = 1'b0;
    is_get = 1'b0;
    unique case (req.action)
      ACT_PUT: is_put = 1'b1;
      ACT_GET: is_get = 1'b1;
      default: ;
    endcase
  end

  assign touch     = req.valid && hit && (is_put || is_get);
  assign insert    = req.valid && !hit && is_put;
  assign target_oh = hit ? match : (grow ? free_oh : victim_oh);

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      rank_we[i]   = 1'b0;
      rank_next[i] = entry_recency[i];
      if (touch || insert) begin
        if (target_oh[i]) begin
          rank_we[i]   = 1'b1;
          rank_next[i] = '0;
        end else if (entry_valid[i] && (insert || (entry_recency[i] < hit_rank))) begin
          rank_we[i]   = 1'b1;
          rank_next[i] = IDX_W'(entry_recency[i] + IDX_W'(1));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      entry_count <= '0;
    end else if (insert) begin
      entry_valid <= entry_valid | target_oh;
      if (grow) begin
        entry_count <= entry_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (rank_we[i]) begin
        entry_recency[i] <= rank_next[i];
      end
      if (req.valid && is_put && target_oh[i]) begin
        entry_data[i] <= req.value;
      end
      if (insert && target_oh[i]) begin
        entry_key[i] <= req.key;
      end
    end
  end

  assign rsp.hit        = hit;
  assign rsp.read_value = (is_get && hit) ? hit_data : '0;
  assign rsp.status     = is_get && !hit;

  `LKVC_ASSERT(a_count_matches_valid, clk, rst, $countones(entry_valid) == int'(entry_count))
  `LKVC_ASSERT(a_key_unique, clk, rst, $onehot0(match))
  `LKVC_ASSERT(a_victim_found, clk, rst, (insert && !grow) |-> $onehot(victim_oh))

endmodule
`default_nettype wire

>>> design/lru_key_value_cache.sv
// Top level of the fully associative key-value cache with LRU replacement.
//
//   Channel   Direction  Handshake            Content
//   s_*       in         s_tvalid/s_tready    request word: action, key, value
//   m_*       out        m_tvalid/m_tready    result word: hit, status, value
//   cfg_*     in         cfg_valid/cfg_ready  max_entries register write
//
// For each request, a request word sits in the input register, the key is
// compared against all entries in parallel and the recency ranks are updated
// in the same cycle that the result is registered.
// One word per cycle is sustained while m_tready holds; the result register
// frees the input side whenever the output is taken or empty.
// Reset clears all entries, the entry count, both pipeline registers and sets
// max_entries to 16. A stall on m_tready holds the result and, once the
// input register is full, drops s_tready; no word is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
`include "lru_key_value_cache_defines.svh"
module lru_key_value_cache (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  // Request word.
  input  wire logic                                        s_tvalid,
  output logic                                             s_tready,
  // key [31:0], write_value [63:32]
  input  wire logic [lkvc_pkg::KEY_W+lkvc_pkg::VAL_W-1:0]  s_tdata,
  // action [1:0]
  input  wire logic [lkvc_pkg::ACT_W-1:0]                  s_tuser,
  // Result word.
  output logic                                             m_tvalid,
  input  wire logic                                        m_tready,
  // read_value [31:0]
  output logic [lkvc_pkg::VAL_W-1:0]                       m_tdata,
  // hit [0], status [1]
  output logic [1:0]                                       m_tuser,
  // Configuration write of max_entries.
  input  wire logic                                        cfg_valid,
  output logic                                             cfg_ready,
  input  wire logic [lkvc_pkg::CFG_W-1:0]                  cfg_data
);
  import lkvc_pkg::*;

  logic [CFG_W-1:0] max_entries;

  // Input register.
  logic             in_vld;
  logic [ACT_W-1:0] in_action;
  logic [KEY_W-1:0] in_key;
  logic [VAL_W-1:0] in_value;

  // Result register.
  logic             out_vld;
  logic             out_hit;
  logic             out_status;
  logic [VAL_W-1:0] out_value;

  logic   advance;
  req_t   req;
  rsp_t   rsp;

  // The word in the input register is processed when the result register
  // can take its result; the store updates at that same edge.
  assign advance  = in_vld && (!out_vld || m_tready);
  assign s_tready = !in_vld || advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= CFG_W'(CFG_RESET);
    end else if (cfg_valid && cfg_ready) begin
      max_entries <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_action <= s_tuser;
      in_key    <= s_tdata[KEY_W-1:0];
      in_value  <= s_tdata[KEY_W+VAL_W-1:KEY_W];
    end
  end

  assign req.valid  = advance;
  assign req.action = action_t'(in_action);
  assign req.key    = in_key;
  assign req.value  = in_value;

  lkvc_store u_store (
    .clk         (clk),
    .rst         (rst),
    .max_entries (max_entries),
    .req         (req),
    .rsp         (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (m_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_hit    <= rsp.hit;
      out_status <= rsp.status;
      out_value  <= rsp.read_value;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = out_value;
  assign m_tuser  = {out_status, out_hit};

  `LKVC_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> (!in_vld && !out_vld))
  `LKVC_ASSERT(a_stalled_word_kept, clk, rst, (in_vld && out_vld && !m_tready) |=> in_vld)
  `LKVC_ASSERT(a_result_follows, clk, rst, advance |=> out_vld)

endmodule
`default_nettype wire

>>> verif/lru_key_value_cache_test.sv
// Self-checking testbench for the LRU key-value cache: directed table, then random traffic.
`timescale 1ns / 1ps
module lru_key_value_cache_test;
  import lkvc_pkg::*;

  // Action 3 has no member in the package; the cache treats it as a presence test.
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

  // Cycles without any handshake before the run is declared hung. Every side
  // idles about a third of the time, so a gap of this size never occurs in a
  // healthy run.
  localparam int STALL_LIMIT  = 5000;
  localparam int PHASE_ITEMS  = 220;
  localparam int PHASE_COUNT  = 8;
  localparam int IDLE_PERCENT = 36;
  localparam int POOL_SIZE    = 32;

  typedef enum logic {ROW_REQUEST, ROW_LIMIT} row_kind_t;

  // One row of the directed table. For a limit row only data is used. For a
  // request row with known set, the result typed in the row is the expected
  // word; otherwise the expected word comes from the cache mirror below.
  typedef struct packed {
    row_kind_t        kind;
    logic [ACT_W-1:0] action;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] data;
    logic             known;
    rsp_t             result;
  } row_t;

  localparam int ROW_COUNT = 27;

  // The table starts right after reset, with max_entries at 16 and every
  // entry empty. Rows with an obvious outcome carry it; the rest are left to
  // the mirror.
  localparam row_t DIRECTED [ROW_COUNT] = '{
    // A get of anything after reset misses and flags status.
    '{ROW_REQUEST, ACT_GET,      32'h0000_0000, 32'h0,          1'b1, '{1'b0, 32'h0, 1'b1}},
    '{ROW_REQUEST, ACT_CONTAINS, 32'hFFFF_FFFF, 32'h0,          1'b1, '{1'b0, 32'h0, 1'b0}},
    '{ROW_REQUEST, ACT_PUT,      32'h0000_0000, 32'hFFFF_FFFF,  1'b1, '{1'b0, 32'h0, 1'b0}},
    '{ROW_REQUEST, ACT_GET,      32'h0000_0000, 32'h0,          1'b1,
      '{1'b1, 32'hFFFF_FFFF, 1'b0}},
    '{ROW_REQUEST, ACT_PUT,      32'hFFFF_FFFF, 32'h0000_0000,  1'b1, '{1'b0, 32'h0, 1'b0}},
    // The unused action reports presence only and returns no value.
    '{ROW_REQUEST, ACT_SPARE,    32'hFFFF_FFFF, 32'hA5A5_A5A5,  1'b1, '{1'b1, 32'h0, 1'b0}},
    // A put of a present key overwrites the value and reports a hit.
    '{ROW_REQUEST, ACT_PUT,      32'h0000_0000, 32'h1234_5678,  1'b1, '{1'b1, 32'h0, 1'b0}},
    '{ROW_REQUEST, ACT_GET,      32'h0000_0000, 32'h0,          1'b1,
      '{1'b1, 32'h1234_5678, 1'b0}},
    '{ROW_REQUEST, ACT_PUT,      32'h0000_0011, 32'h1111_1111,  1'b0, '0},
    '{ROW_REQUEST, ACT_PUT,      32'h0000_0022, 32'h2222_2222,  1'b0, '0},
    '{ROW_REQUEST, ACT_GET,      32'hFFFF_FFFF, 32'h0,          1'b0, '0},
    // Lower the limit below the four entries in use; the next new key
    // replaces the least recent entry without changing the count.
    '{ROW_LIMIT,   ACT_PUT,      32'h0,         32'd2,          1'b0, '0},
    '{ROW_REQUEST, ACT_PUT,      32'h0000_0044, 32'h4444_4444,  1'b0, '0},
    '{ROW_REQUEST, ACT_GET,      32'h0000_0000, 32'h0,          1'b0, '0},
    // A limit of zero behaves as a limit of one.
    '{ROW_LIMIT,   ACT_PUT,      32'h0,         32'd0,          1'b0, '0},
    '{ROW_REQUEST, ACT_PUT,      32'h0000_0055, 32'h5555_5555,  1'b0, '0},
    '{ROW_REQUEST, ACT_GET,      32'h0000_0055, 32'h0,          1'b0, '0},
    '{ROW_REQUEST, ACT_GET,      32'h0000_0044, 32'h0,          1'b0, '0},
    // A limit above the capacity behaves as the full capacity.
    '{ROW_LIMIT,   ACT_PUT,      32'h0,         32'd31,         1'b0, '0},
    '{ROW_REQUEST, ACT_PUT,      32'h0000_0066, 32'h6666_6666,  1'b0, '0},
    '{ROW_REQUEST, ACT_CONTAINS, 32'h0000_0055, 32'h0,          1'b0, '0},
    '{ROW_LIMIT,   ACT_PUT,      32'h0,         32'd1,          1'b0, '0},
    '{ROW_REQUEST, ACT_PUT,      32'h0000_0077, 32'h0000_0000,  1'b0, '0},
    '{ROW_REQUEST, ACT_GET,      32'h0000_0066, 32'h0,          1'b0, '0},
    '{ROW_REQUEST, ACT_GET,      32'h0000_0077, 32'h0,          1'b0, '0},
    '{ROW_LIMIT,   ACT_PUT,      32'h0,         32'd16,         1'b0, '0},
    '{ROW_REQUEST, ACT_PUT,      32'hFFFF_FFFF, 32'hFFFF_FFFF,  1'b0, '0}
  };

  // Every input has a known value from time zero.
  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [KEY_W+VAL_W-1:0] s_tdata   = '0;
  logic [ACT_W-1:0]       s_tuser   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [VAL_W-1:0]       m_tdata;
  logic [1:0]             m_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data  = '0;

  // When set, neither side idles; one random phase runs this way.
  bit steady = 1'b0;
  int failures = 0;
  int stall_cycles = 0;

  // Results the cache owes, oldest first.
  rsp_t owed_results[$];

  // Mirror of the cache contents. Ages rank the valid entries, 0 being the
  // most recently used.
  logic             mirror_valid [CAPACITY];
  logic [KEY_W-1:0] mirror_key   [CAPACITY];
  logic [VAL_W-1:0] mirror_data  [CAPACITY];
  logic [3:0]       mirror_age   [CAPACITY];
  int               mirror_count;
  logic [CFG_W-1:0] mirror_limit;

  lru_key_value_cache dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit idle_roll();
    return !steady && ($urandom_range(99) < IDLE_PERCENT);
  endfunction

  // Move an entry to the front: every entry younger than it ages by one.
  function automatic void promote(int slot);
    logic [3:0] old_age;
    old_age = mirror_age[slot];
    for (int i = 0; i < CAPACITY; i++) begin
      if (i != slot && mirror_valid[i] && mirror_age[i] < old_age) begin
        mirror_age[i] = mirror_age[i] + 4'd1;
      end
    end
    mirror_age[slot] = 4'd0;
  endfunction

  // Apply one request to the mirror and return the word the cache must send.
  function automatic rsp_t predict_access(logic [ACT_W-1:0] act, logic [KEY_W-1:0] k,
                                          logic [VAL_W-1:0] v);
    rsp_t outcome;
    int   slot;
    int   lim;
    bit   grow;
    slot = -1;
    outcome = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (slot < 0 && mirror_valid[i] && mirror_key[i] == k) begin
        slot = i;
      end
    end
    outcome.hit = (slot >= 0);
    if (act == ACT_PUT) begin
      if (slot >= 0) begin
        mirror_data[slot] = v;
        promote(slot);
      end else begin
        lim = (mirror_limit == 0) ? 1 : int'(mirror_limit);
        if (lim > CAPACITY) begin
          lim = CAPACITY;
        end
        grow = 1'b0;
        // Take a free entry while below the limit, else replace the oldest.
        if (mirror_count < lim) begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (slot < 0 && !mirror_valid[i]) begin
              slot = i;
              grow = 1'b1;
            end
          end
        end
        if (slot < 0) begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (mirror_valid[i] && (slot < 0 || mirror_age[i] > mirror_age[slot])) begin
              slot = i;
            end
          end
        end
        // The replaced entry held the largest age, so nobody overflows.
        for (int i = 0; i < CAPACITY; i++) begin
          if (i != slot && mirror_valid[i]) begin
            mirror_age[i] = mirror_age[i] + 4'd1;
          end
        end
        mirror_valid[slot] = 1'b1;
        mirror_key[slot]   = k;
        mirror_data[slot]  = v;
        mirror_age[slot]   = 4'd0;
        if (grow) begin
          mirror_count++;
        end
      end
    end else if (act == ACT_GET) begin
      if (slot >= 0) begin
        outcome.read_value = mirror_data[slot];
        promote(slot);
      end else begin
        outcome.status = 1'b1;
      end
    end
    return outcome;
  endfunction

  // Present one request word, with random idle cycles ahead of it, and hold
  // it until the cache takes it. The valid stays high on return, so a word
  // that follows at once goes out back to back.
  task automatic send_request(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] k,
                              input logic [VAL_W-1:0] v, input logic known,
                              input rsp_t given);
    rsp_t predicted;
    while (idle_roll()) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    predicted = predict_access(act, k, v);
    owed_results.push_back(known ? given : predicted);
    s_tvalid <= 1'b1;
    s_tdata  <= {v, k};
    s_tuser  <= act;
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop sending and wait until every owed result has come back. Each
  // request yields exactly one result, so the cache is idle once the queue
  // is empty.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (owed_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Write max_entries while the cache is idle.
  task automatic write_limit(input logic [CFG_W-1:0] limit);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= limit;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mirror_limit = limit;
  endtask

  // Result side: check each accepted word against the oldest owed result,
  // then decide whether to stall the next cycle.
  always @(posedge clk) begin : result_check
    rsp_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (owed_results.size() == 0) begin
        $error("result word with no request outstanding: hit %0d status %0d value %h",
               m_tuser[0], m_tuser[1], m_tdata);
        failures++;
      end else begin
        want = owed_results.pop_front();
        // m_tuser carries hit in bit 0 and status in bit 1.
        if (m_tuser[0] !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, m_tuser[0]);
          failures++;
        end
        if (m_tdata !== want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, m_tdata);
          failures++;
        end
        if (m_tuser[1] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tuser[1]);
          failures++;
        end
      end
    end
    m_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("lru_key_value_cache test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    logic [CFG_W-1:0] phase_limit;
    logic [ACT_W-1:0] act;
    logic [KEY_W-1:0] k;
    logic [VAL_W-1:0] v;
    int               pool_used;
    int               roll;

    for (int i = 0; i < CAPACITY; i++) begin
      mirror_valid[i] = 1'b0;
      mirror_key[i]   = '0;
      mirror_data[i]  = '0;
      mirror_age[i]   = '0;
    end
    mirror_count = 0;
    mirror_limit = CFG_W'(CFG_RESET);

    // A pool of keys makes hits and evictions frequent; the all-zero and
    // all-one keys are always part of it.
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) begin
      key_pool[i] = $urandom;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].kind == ROW_LIMIT) begin
        write_limit(DIRECTED[r].data[CFG_W-1:0]);
      end else begin
        send_request(DIRECTED[r].action, DIRECTED[r].key, DIRECTED[r].data,
                     DIRECTED[r].known, DIRECTED[r].result);
      end
    end

    // Random phases, each under its own limit. The list covers the extremes
    // and the out-of-range settings; going from a large limit to a small one
    // leaves the cache over the new limit, so replacement without growth is
    // exercised as well.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin
          phase_limit = 5'd16;
        end
        1: begin
          phase_limit = 5'd1;
        end
        2: begin
          phase_limit = 5'd31;
        end
        3: begin
          phase_limit = 5'd0;
        end
        4: begin
          phase_limit = 5'd17;
        end
        5: begin
          phase_limit = 5'd3;
        end
        6: begin
          phase_limit = 5'd8;
        end
        default: begin
          phase_limit = CFG_W'($urandom_range(31));
        end
      endcase
      write_limit(phase_limit);
      steady = (phase == 2);

      // Keep the working set a little larger than the usable entries.
      pool_used = ((phase_limit == 0) ? 1 : (phase_limit > CAPACITY) ? CAPACITY :
                   int'(phase_limit)) + $urandom_range(1, 6);
      if (pool_used > POOL_SIZE) begin
        pool_used = POOL_SIZE;
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(99);
        if (roll < 35) begin
          act = ACT_PUT;
        end else if (roll < 70) begin
          act = ACT_GET;
        end else if (roll < 90) begin
          act = ACT_CONTAINS;
        end else begin
          act = ACT_SPARE;
        end
        k = ($urandom_range(99) < 85) ? key_pool[$urandom_range(pool_used - 1)] : $urandom;
        roll = $urandom_range(99);
        v = (roll < 10) ? '0 : (roll < 20) ? '1 : $urandom;
        send_request(act, k, v, 1'b0, '0);
      end
    end
    steady = 1'b0;

    drain();
    // The pipeline is two stages deep; the extra wait catches any stray word.
    repeat (4) @(posedge clk);
    if (failures == 0) begin
      $display("lru_key_value_cache test passed");
    end else begin
      $display("lru_key_value_cache test failed");
    end
    $finish;
  end

endmodule
